// ===== rtl/absc_pkg.sv =====
package absc_pkg;

  localparam int unsigned TOTAL_WIDTH_DEF = 48;

  localparam int unsigned CR_W   = 32;
  localparam int unsigned OR_W   = 18;
  localparam int unsigned FS_W   = 16;
  localparam int unsigned MS_W   = 16;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned Q_W    = 16;
  localparam int unsigned STAT_W = 32;
  localparam int unsigned SUM_W  = 48;
  localparam int unsigned EXT_W  = 64;

  // elapsed ticks * sample rate, and the divider built around it
  localparam int unsigned PROD_W = TIME_W + OR_W;
  localparam int unsigned CONS_W = FS_W + 2;
  localparam int unsigned PRD_W  = FS_W + 4;

  localparam int unsigned MIN_BATCH   = 16;
  localparam int unsigned ALIGN_BITS  = 4;
  localparam int unsigned FRAME_RATE  = 30;
  // floor(x / 30) == (x * RECIP) >> SHIFT for every 18-bit x
  localparam int unsigned RECIP_SHIFT = 23;
  localparam int unsigned FRAME_RECIP = ((1 << RECIP_SHIFT) + FRAME_RATE - 1) / FRAME_RATE;
  localparam int unsigned RECIP_PW    = RECIP_SHIFT + FS_W;

  localparam logic [CR_W-1:0] CR_RST   = '0;
  localparam logic [OR_W-1:0] OR_RST   = OR_W'(48000);
  localparam logic [FS_W-1:0] FS_RST   = '0;
  localparam logic [MS_W-1:0] MS_RST   = MS_W'(4096);
  localparam logic [Q_W-1:0]  MINQ_RST = '1;

  typedef enum logic [1:0] {
    CFG_TICK_RATE   = 2'd0,
    CFG_SAMPLE_RATE = 2'd1,
    CFG_FRAME_SIZE  = 2'd2,
    CFG_MAX_SAMPLES = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic              sink_live;
    logic [TIME_W-1:0] tick_now;
    logic [Q_W-1:0]    queue_depth;
  } in_t;

  typedef struct packed {
    logic [FS_W-1:0]   produce_count;
    logic [STAT_W-1:0] stall_guard_count;
    logic [STAT_W-1:0] live_decision_count;
    logic [SUM_W-1:0]  consumed_total;
    logic [STAT_W-1:0] empty_queue_count;
    logic [Q_W-1:0]    min_queue_seen;
    logic [Q_W-1:0]    max_queue_seen;
    logic [SUM_W-1:0]  produced_total;
    logic [FS_W-1:0]   max_produce_seen;
  } out_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic pick;
    logic sum;
    logic commit;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/absc_div.sv =====
module absc_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [absc_pkg::PROD_W-1:0] dividend,
  input  logic [absc_pkg::CR_W-1:0]   divisor,
  output logic                        done,
  output logic [absc_pkg::PROD_W-1:0] quotient
);

  localparam int unsigned DVD_W = absc_pkg::PROD_W;
  localparam int unsigned DVS_W = absc_pkg::CR_W;
  localparam int unsigned CNT_W = $clog2(DVD_W);

  logic [DVS_W-1:0] rem_r;
  logic [DVD_W-1:0] quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // restoring divider, one quotient bit per cycle; dividend shifts out as quotient shifts in
  assign rem_sh = {rem_r, quo_r[DVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, divisor};
  assign ge     = ~diff[DVS_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== rtl/absc_dp.sv =====
module absc_dp #(
  parameter int unsigned TOTAL_WIDTH = absc_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  absc_pkg::cfg_idx_t       cfg_index,
  input  logic [31:0]              cfg_data,
  input  absc_pkg::in_t            in_data,
  input  absc_pkg::cmd_t           cmd,
  output absc_pkg::sts_t           sts,
  output logic                     out_valid,
  input  logic                     out_ready,
  output absc_pkg::out_t           out_data
);

  localparam int unsigned OR_W    = absc_pkg::OR_W;
  localparam int unsigned FS_W    = absc_pkg::FS_W;
  localparam int unsigned Q_W     = absc_pkg::Q_W;
  localparam int unsigned PROD_W  = absc_pkg::PROD_W;
  localparam int unsigned CONS_W  = absc_pkg::CONS_W;
  localparam int unsigned PRD_W   = absc_pkg::PRD_W;
  localparam int unsigned RPW     = absc_pkg::RECIP_PW;
  localparam int unsigned ALIGN   = absc_pkg::ALIGN_BITS;
  localparam int unsigned EXT_W_L = absc_pkg::EXT_W;

  // configuration
  logic [absc_pkg::CR_W-1:0] tick_rate_r;
  logic [OR_W-1:0]           sample_rate_r;
  logic [FS_W-1:0]           frame_size_r;
  logic [absc_pkg::MS_W-1:0] max_samples_r;

  // statistics and time reference
  logic                        have_last_r;
  logic [absc_pkg::TIME_W-1:0] last_time_r;
  logic [absc_pkg::STAT_W-1:0] stall_r;
  logic [absc_pkg::STAT_W-1:0] live_r;
  logic [TOTAL_WIDTH-1:0]      cons_sum_r;
  logic [absc_pkg::STAT_W-1:0] empty_r;
  logic [Q_W-1:0]              min_q_r;
  logic [Q_W-1:0]              max_q_r;
  logic [TOTAL_WIDTH-1:0]      prod_sum_r;
  logic [FS_W-1:0]             max_prod_r;

  // per-request working registers
  logic                        sink_r;
  logic [absc_pkg::TIME_W-1:0] now_r;
  logic [Q_W-1:0]              queued_r;
  logic [FS_W-1:0]             frame_r;
  logic [PROD_W-1:0]           prod_r;
  logic [CONS_W-1:0]           consumed_r;
  logic                        guard_r;
  logic [FS_W-1:0]             produce_r;

  logic                        out_valid_r;
  absc_pkg::out_t              out_data_r;

  logic [RPW-1:0]              recip_prod;
  logic [FS_W-1:0]             quot30;
  logic [FS_W-1:0]             eff_frame;
  logic [absc_pkg::TIME_W-1:0] elapsed;
  logic                        limit_low;
  logic                        need_div;
  logic                        div_done;
  logic [PROD_W-1:0]           quo;
  logic                        over;
  logic signed [PRD_W-1:0]     est;
  logic signed [PRD_W-1:0]     base;
  logic [FS_W-1:0]             clamped;
  logic [EXT_W_L-1:0]          cons_ext;
  logic [EXT_W_L-1:0]          prod_ext;

  assign recip_prod = RPW'(sample_rate_r) * RPW'(absc_pkg::FRAME_RECIP);
  assign quot30     = recip_prod[absc_pkg::RECIP_SHIFT +: FS_W];

  always_comb begin
    if (frame_size_r != '0) begin
      eff_frame = frame_size_r;
    end else if (quot30 != '0) begin
      eff_frame = quot30;
    end else begin
      eff_frame = FS_W'(absc_pkg::MIN_BATCH);
    end
  end

  assign elapsed   = in_data.tick_now - last_time_r;
  assign limit_low = max_samples_r < absc_pkg::MS_W'(absc_pkg::MIN_BATCH);
  assign need_div  = sink_r && !limit_low && have_last_r && (tick_rate_r != '0);

  absc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (tick_rate_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign over = need_div && (quo > PROD_W'({frame_r, 2'b00}));

  assign est = $signed(PRD_W'(consumed_r)) + $signed(PRD_W'(frame_r))
             - $signed(PRD_W'(queued_r));
  assign base = sink_r ? est : $signed(PRD_W'(frame_r));

  always_comb begin
    if (base < $signed(PRD_W'(absc_pkg::MIN_BATCH))) begin
      clamped = FS_W'(absc_pkg::MIN_BATCH);
    end else if (base > $signed(PRD_W'(max_samples_r))) begin
      clamped = max_samples_r;
    end else begin
      clamped = base[FS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_rate_r   <= absc_pkg::CR_RST;
      sample_rate_r <= absc_pkg::OR_RST;
      frame_size_r  <= absc_pkg::FS_RST;
      max_samples_r <= absc_pkg::MS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        absc_pkg::CFG_TICK_RATE:   tick_rate_r   <= cfg_data;
        absc_pkg::CFG_SAMPLE_RATE: sample_rate_r <= cfg_data[OR_W-1:0];
        absc_pkg::CFG_FRAME_SIZE:  frame_size_r  <= cfg_data[FS_W-1:0];
        absc_pkg::CFG_MAX_SAMPLES: max_samples_r <= cfg_data[absc_pkg::MS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sink_r   <= in_data.sink_live;
      now_r    <= in_data.tick_now;
      queued_r <= in_data.queue_depth;
      frame_r  <= eff_frame;
      prod_r   <= PROD_W'(elapsed) * PROD_W'(sample_rate_r);
    end
    if (cmd.pick) begin
      consumed_r <= (need_div && !over) ? quo[CONS_W-1:0] : CONS_W'(frame_r >> 1);
      guard_r    <= have_last_r && ((tick_rate_r == '0) || over);
    end
    if (cmd.sum) begin
      produce_r <= limit_low ? '0 : {clamped[FS_W-1:ALIGN], {ALIGN{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_last_r <= 1'b0;
      last_time_r <= '0;
      stall_r     <= '0;
      live_r      <= '0;
      cons_sum_r  <= '0;
      empty_r     <= '0;
      min_q_r     <= absc_pkg::MINQ_RST;
      max_q_r     <= '0;
      prod_sum_r  <= '0;
      max_prod_r  <= '0;
    end else if (cmd.commit && sink_r && !limit_low) begin
      have_last_r <= 1'b1;
      last_time_r <= now_r;
      live_r      <= live_r + 1'b1;
      cons_sum_r  <= cons_sum_r + TOTAL_WIDTH'(consumed_r);
      prod_sum_r  <= prod_sum_r + TOTAL_WIDTH'(produce_r);
      if (guard_r) begin
        stall_r <= stall_r + 1'b1;
      end
      if (queued_r == '0) begin
        empty_r <= empty_r + 1'b1;
      end
      if (queued_r < min_q_r) begin
        min_q_r <= queued_r;
      end
      if (queued_r > max_q_r) begin
        max_q_r <= queued_r;
      end
      if (produce_r > max_prod_r) begin
        max_prod_r <= produce_r;
      end
    end
  end

  assign cons_ext = EXT_W_L'(cons_sum_r);
  assign prod_ext = EXT_W_L'(prod_sum_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data_r.produce_count       <= produce_r;
      out_data_r.stall_guard_count   <= stall_r;
      out_data_r.live_decision_count <= live_r;
      out_data_r.consumed_total      <= cons_ext[absc_pkg::SUM_W-1:0];
      out_data_r.empty_queue_count   <= empty_r;
      out_data_r.min_queue_seen      <= min_q_r;
      out_data_r.max_queue_seen      <= max_q_r;
      out_data_r.produced_total      <= prod_ext[absc_pkg::SUM_W-1:0];
      out_data_r.max_produce_seen    <= max_prod_r;
    end
  end

  assign sts.need_div = need_div;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.produce_count[ALIGN-1:0] == '0))
    else $error("produce count not a multiple of the batch granule");

  a_first_live: assert property (@(posedge clk) disable iff (!rst_n)
    !have_last_r |-> (live_r == '0))
    else $error("live decisions counted without a time reference");

  a_div_need: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> need_div)
    else $error("divider started on a request that needs no estimate");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.live_decision_count != '0))
      |-> (out_data_r.min_queue_seen <= out_data_r.max_queue_seen))
    else $error("queue minimum above maximum");
`endif

endmodule

// ===== rtl/absc_ctrl.sv =====
module absc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  absc_pkg::sts_t sts,
  output absc_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV,
    ST_PICK,
    ST_SUM,
    ST_COMMIT,
    ST_PUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_valid) state_nxt = ST_START;
      ST_START:  state_nxt = sts.need_div ? ST_DIV : ST_PICK;
      ST_DIV:    if (sts.div_done) state_nxt = ST_PICK;
      ST_PICK:   state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_COMMIT;
      ST_COMMIT: state_nxt = ST_PUSH;
      ST_PUSH:   if (sts.out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign cmd.capture   = in_valid && in_ready;
  assign cmd.div_start = (state_r == ST_START) && sts.need_div;
  assign cmd.pick      = (state_r == ST_PICK);
  assign cmd.sum       = (state_r == ST_SUM);
  assign cmd.commit    = (state_r == ST_COMMIT);
  // result waits here until the output register frees up
  assign cmd.push      = (state_r == ST_PUSH) && sts.out_free;

endmodule

// ===== rtl/audio_batch_size_controller.sv =====
// Channel   Signals                                   Direction
// in        in_valid, in_ready, in_data (in_t)        request beat in
// out       out_valid, out_ready, out_data (out_t)    result beat out
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data register write in
//
// One request at a time. A live request with a time reference, a nonzero
// tick rate and a sample limit of at least MIN_BATCH runs the
// 50-step restoring divider (elapsed ticks * sample rate / tick rate);
// every other request skips it. The next request is accepted once the result is registered.
// Synchronous active-low reset; no clearing pass. cfg is always ready.
// A stalled result holds in the output register and blocks only the next push.
module audio_batch_size_controller #(
  parameter int unsigned TOTAL_WIDTH = absc_pkg::TOTAL_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  absc_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output absc_pkg::out_t     out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  absc_pkg::cfg_idx_t cfg_index,
  input  logic [31:0]        cfg_data
);

  absc_pkg::cmd_t cmd;
  absc_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  absc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  absc_dp #(
    .TOTAL_WIDTH (TOTAL_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
